### src/cpuaf_pkg.sv
// Shared types and codes of the MOV/ADD/SUB/CMP execute unit.
`default_nettype none

package cpuaf_pkg;

    localparam logic [2:0] KIND_MOV = 3'd0;
    localparam logic [2:0] KIND_ADD = 3'd1;
    localparam logic [2:0] KIND_SUB = 3'd2;
    localparam logic [2:0] KIND_CMP = 3'd3;

    localparam logic [1:0] SRC_IMM = 2'd0;
    localparam logic [1:0] SRC_GEN = 2'd1;
    localparam logic [1:0] SRC_SEG = 2'd2;
    localparam logic [1:0] SRC_MEM = 2'd3;

    localparam int GEN_DEPTH = 8;
    localparam int SEG_DEPTH = 4;

    typedef struct packed {
        logic af;
        logic of;
        logic cf;
        logic pf;
        logic sf;
        logic zf;
    } flags_t;

    // Decoded instruction held in the execute stage. wide is the effective
    // operand width (segment moves are forced to 16 bits).
    typedef struct packed {
        logic [2:0]  kind;
        logic        wide;
        logic        dseg;
        logic [2:0]  didx;
        logic [1:0]  stype;
        logic [2:0]  sidx;
        logic [15:0] imm;
    } item_t;

    typedef struct packed {
        logic [2:0] gen_a_addr;
        logic [2:0] gen_b_addr;
        logic [1:0] seg_addr;
    } rd_req_t;

    typedef struct packed {
        logic        gen_we;
        logic        seg_we;
        logic [2:0]  gen_addr;
        logic [1:0]  seg_addr;
        logic [15:0] data;
    } wr_req_t;

    typedef struct packed {
        wr_req_t     wr;
        logic        flags_we;
        flags_t      flags;
        logic [15:0] value;
        logic        written;
    } alu_res_t;

endpackage

`default_nettype wire

### src/cpuaf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cpuaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/cpuaf_regfile.sv
// General and segment register files with valid bits and write forwarding.
`default_nettype none

module cpuaf_regfile
    import cpuaf_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    rd_en,
    input  wire rd_req_t rd,
    input  wire wr_req_t wr,
    output      logic [15:0] gen_a,
    output      logic [15:0] gen_b,
    output      logic [15:0] seg
);

    logic [15:0] gen_a_q;
    logic [15:0] gen_b_q;
    logic [15:0] seg_q;

    logic [GEN_DEPTH-1:0] gen_vld_reg;
    logic [SEG_DEPTH-1:0] seg_vld_reg;
    logic gen_a_vld_reg, gen_b_vld_reg, seg_vld_cap_reg;
    logic gen_a_hit_reg, gen_b_hit_reg, seg_hit_reg;
    logic [15:0] fwd_data_reg;

    // Two copies of the general file give two read ports.
    cpuaf_ram #(.WIDTH(16), .DEPTH(GEN_DEPTH)) u_gen_a (
        .aclk(aclk), .we(wr.gen_we), .waddr(wr.gen_addr), .wdata(wr.data),
        .re(rd_en), .raddr(rd.gen_a_addr), .rdata(gen_a_q)
    );

    cpuaf_ram #(.WIDTH(16), .DEPTH(GEN_DEPTH)) u_gen_b (
        .aclk(aclk), .we(wr.gen_we), .waddr(wr.gen_addr), .wdata(wr.data),
        .re(rd_en), .raddr(rd.gen_b_addr), .rdata(gen_b_q)
    );

    cpuaf_ram #(.WIDTH(16), .DEPTH(SEG_DEPTH)) u_seg (
        .aclk(aclk), .we(wr.seg_we), .waddr(wr.seg_addr), .wdata(wr.data),
        .re(rd_en), .raddr(rd.seg_addr), .rdata(seg_q)
    );

    // A write landing on the same edge as a read is not seen by the RAM
    // read, so its data is captured and substituted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_vld_reg     <= '0;
            seg_vld_reg     <= '0;
            gen_a_vld_reg   <= 1'b0;
            gen_b_vld_reg   <= 1'b0;
            seg_vld_cap_reg <= 1'b0;
            gen_a_hit_reg   <= 1'b0;
            gen_b_hit_reg   <= 1'b0;
            seg_hit_reg     <= 1'b0;
        end else begin
            if (wr.gen_we) begin
                gen_vld_reg[wr.gen_addr] <= 1'b1;
            end
            if (wr.seg_we) begin
                seg_vld_reg[wr.seg_addr] <= 1'b1;
            end
            if (rd_en) begin
                gen_a_vld_reg   <= gen_vld_reg[rd.gen_a_addr];
                gen_b_vld_reg   <= gen_vld_reg[rd.gen_b_addr];
                seg_vld_cap_reg <= seg_vld_reg[rd.seg_addr];
                gen_a_hit_reg   <= wr.gen_we && (wr.gen_addr == rd.gen_a_addr);
                gen_b_hit_reg   <= wr.gen_we && (wr.gen_addr == rd.gen_b_addr);
                seg_hit_reg     <= wr.seg_we && (wr.seg_addr == rd.seg_addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_data_reg <= wr.data;
        end
    end

    always_comb begin
        gen_a = gen_a_hit_reg ? fwd_data_reg : (gen_a_vld_reg ? gen_a_q : 16'h0000);
        gen_b = gen_b_hit_reg ? fwd_data_reg : (gen_b_vld_reg ? gen_b_q : 16'h0000);
        seg   = seg_hit_reg ? fwd_data_reg : (seg_vld_cap_reg ? seg_q : 16'h0000);
    end

endmodule

`default_nettype wire

### src/cpuaf_alu.sv
// Operand selection, add/subtract, flag logic and write-back word merge.
`default_nettype none

module cpuaf_alu
    import cpuaf_pkg::*;
(
    input  wire item_t       item,
    input  wire flags_t      flags_cur,
    input  wire logic [15:0] gen_a,
    input  wire logic [15:0] gen_b,
    input  wire logic [15:0] seg,
    output      alu_res_t    res
);

    logic        hi_d, hi_s;
    logic        ignored, is_mov, is_arith, is_add;
    logic [15:0] a, b, src_gen, mask, sign, r, v, merged;
    logic [16:0] sum, diff;
    flags_t      fnew;

    always_comb begin
        hi_d = !item.wide && item.didx[2];
        hi_s = !item.wide && item.sidx[2];

        a       = item.wide ? gen_a : {8'h00, (hi_d ? gen_a[15:8] : gen_a[7:0])};
        src_gen = item.wide ? gen_b : {8'h00, (hi_s ? gen_b[15:8] : gen_b[7:0])};

        case (item.stype)
            SRC_IMM: b = item.wide ? item.imm : {8'h00, item.imm[7:0]};
            SRC_GEN: b = src_gen;
            SRC_SEG: b = seg;
            default: b = 16'h0000;
        endcase

        mask = item.wide ? 16'hFFFF : 16'h00FF;
        sign = item.wide ? 16'h8000 : 16'h0080;

        ignored  = (item.kind > KIND_CMP) || (item.stype == SRC_MEM);
        is_mov   = !ignored && (item.kind == KIND_MOV);
        is_arith = !ignored && (item.kind != KIND_MOV) && !item.dseg
                   && (item.stype != SRC_SEG);
        is_add   = (item.kind == KIND_ADD);

        sum  = {1'b0, a} + {1'b0, b};
        diff = {1'b0, a} - {1'b0, b};
        r    = (is_add ? sum[15:0] : diff[15:0]) & mask;

        fnew.cf = is_add ? (item.wide ? sum[16] : sum[8]) : diff[16];
        fnew.of = is_add ? (|((a ^ r) & (b ^ r) & sign)) : (|((a ^ b) & (a ^ r) & sign));
        fnew.af = a[4] ^ b[4] ^ r[4];
        fnew.zf = (r == 16'h0000);
        fnew.sf = |(r & sign);
        fnew.pf = ~^r[7:0];

        // Byte writes keep the other half of the destination word.
        v = is_mov ? b : r;
        if (item.wide) begin
            merged = v;
        end else if (hi_d) begin
            merged = {v[7:0], gen_a[7:0]};
        end else begin
            merged = {gen_a[15:8], v[7:0]};
        end

        res.wr.gen_we   = (is_mov && !item.dseg) || (is_arith && (item.kind != KIND_CMP));
        res.wr.seg_we   = is_mov && item.dseg;
        res.wr.gen_addr = item.wide ? item.didx : {1'b0, item.didx[1:0]};
        res.wr.seg_addr = item.didx[1:0];
        res.wr.data     = item.dseg ? b : merged;
        res.flags_we    = is_arith;
        res.flags       = is_arith ? fnew : flags_cur;
        res.value       = is_arith ? r : (is_mov ? b : 16'h0000);
        res.written     = res.wr.gen_we || res.wr.seg_we;
    end

endmodule

`default_nettype wire

### src/cpu_alu_mov_add_sub_flags_unit.sv
// Top level of the 16-bit MOV/ADD/SUB/CMP execute unit with flags.
//
// This unit executes one decoded 16-bit x86-style instruction per transfer
// against eight general registers (byte codes name AL..BH) and four segment
// registers, all zero after reset, and returns one result transfer for each
// input transfer: the moved or computed value, whether a register was
// written, and the six arithmetic flags after the instruction. MOV leaves
// the flags alone; ADD, SUB and CMP set ZF, SF, PF, CF, OF and AF at the
// operand width, and CMP writes no register. Memory sources, unknown kinds
// and arithmetic on segment operands change nothing and return a zero value.
// The registers live in small synchronous RAMs with a registered read. An
// input transfer issues its register reads at the accepting edge, the
// execute stage then computes and writes back as it advances, and the
// result sits in an output register until it is taken.
// The unit sustains one instruction per cycle while the result port is not
// stalled; a write that lands on the same edge as the following
// instruction's read is forwarded, so dependent instructions issue back to
// back without a stall. A stalled result port holds the execute stage and
// then the input port.
`default_nettype none

module cpu_alu_mov_add_sub_flags_unit
    import cpuaf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [2:0]  s_kind,
    input  wire logic        s_wide,
    input  wire logic        s_dest_is_segment,
    input  wire logic [2:0]  s_dest_index,
    input  wire logic [1:0]  s_src_type,
    input  wire logic [2:0]  s_src_index,
    input  wire logic [15:0] s_immediate,

    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [15:0] m_result_value,
    output      logic        m_written,
    output      logic        m_zero_flag,
    output      logic        m_sign_flag,
    output      logic        m_parity_flag,
    output      logic        m_carry_flag,
    output      logic        m_overflow_flag,
    output      logic        m_aux_flag
);

    logic     s_accept;
    logic     wide_eff;
    rd_req_t  rd;
    wr_req_t  wr;

    logic     ex_valid_reg;
    item_t    ex_item_reg;
    logic     ex_adv;

    logic [15:0] gen_a, gen_b, seg;
    alu_res_t    res;
    flags_t      flag_reg;

    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic        out_written_reg;
    flags_t      out_flags_reg;

    // The execute stage moves on whenever the output register is free or
    // being emptied in this cycle.
    assign ex_adv   = ex_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !ex_valid_reg || ex_adv;
    assign s_accept = s_valid && s_ready;

    // Segment moves are always full width, so they address whole words.
    always_comb begin
        wide_eff = s_wide || ((s_kind == KIND_MOV)
                              && (s_dest_is_segment || (s_src_type == SRC_SEG)));
        rd.gen_a_addr = wide_eff ? s_dest_index : {1'b0, s_dest_index[1:0]};
        rd.gen_b_addr = wide_eff ? s_src_index : {1'b0, s_src_index[1:0]};
        rd.seg_addr   = s_src_index[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else if (s_ready) begin
            ex_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ex_item_reg.kind  <= s_kind;
            ex_item_reg.wide  <= wide_eff;
            ex_item_reg.dseg  <= s_dest_is_segment;
            ex_item_reg.didx  <= s_dest_index;
            ex_item_reg.stype <= s_src_type;
            ex_item_reg.sidx  <= s_src_index;
            ex_item_reg.imm   <= s_immediate;
        end
    end

    cpuaf_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd      (rd),
        .wr      (wr),
        .gen_a   (gen_a),
        .gen_b   (gen_b),
        .seg     (seg)
    );

    cpuaf_alu u_alu (
        .item      (ex_item_reg),
        .flags_cur (flag_reg),
        .gen_a     (gen_a),
        .gen_b     (gen_b),
        .seg       (seg),
        .res       (res)
    );

    // Writes commit only on the edge at which the instruction retires, so a
    // stalled instruction never writes twice.
    always_comb begin
        wr        = res.wr;
        wr.gen_we = res.wr.gen_we && ex_adv;
        wr.seg_we = res.wr.seg_we && ex_adv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ex_adv && res.flags_we) begin
                flag_reg <= res.flags;
            end
            if (ex_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_adv) begin
            out_value_reg   <= res.value;
            out_written_reg <= res.written;
            out_flags_reg   <= res.flags;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_value  = out_value_reg;
    assign m_written       = out_written_reg;
    assign m_zero_flag     = out_flags_reg.zf;
    assign m_sign_flag     = out_flags_reg.sf;
    assign m_parity_flag   = out_flags_reg.pf;
    assign m_carry_flag    = out_flags_reg.cf;
    assign m_overflow_flag = out_flags_reg.of;
    assign m_aux_flag      = out_flags_reg.af;

endmodule

`default_nettype wire

### src/cpuaf_checker.sv
// Port-level checker for the execute unit and its bind to the top level.
`default_nettype none

module cpuaf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [2:0]  s_kind,
    input wire logic        s_wide,
    input wire logic        s_dest_is_segment,
    input wire logic [2:0]  s_dest_index,
    input wire logic [1:0]  s_src_type,
    input wire logic [2:0]  s_src_index,
    input wire logic [15:0] s_immediate,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_result_value,
    input wire logic        m_written,
    input wire logic        m_zero_flag,
    input wire logic        m_sign_flag,
    input wire logic        m_parity_flag,
    input wire logic        m_carry_flag,
    input wire logic        m_overflow_flag,
    input wire logic        m_aux_flag
);

    // An offered input transfer stays steady until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_kind) && $stable(s_wide)
                                   && $stable(s_dest_is_segment)
                                   && $stable(s_dest_index) && $stable(s_src_type)
                                   && $stable(s_src_index) && $stable(s_immediate)))
        else $error("input changed while stalled");

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_value)
                                   && $stable(m_written) && $stable(m_zero_flag)
                                   && $stable(m_sign_flag) && $stable(m_parity_flag)
                                   && $stable(m_carry_flag) && $stable(m_overflow_flag)
                                   && $stable(m_aux_flag)))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With the output register empty the pipeline can always take a transfer.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // An unwritten nonzero result can only come from a compare, whose flags
    // describe that result.
    a_cmp_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_written && (m_result_value != 16'h0000))
        |-> (!m_zero_flag && (m_parity_flag == ~^m_result_value[7:0])))
        else $error("compare flags do not match its result");

endmodule

bind cpu_alu_mov_add_sub_flags_unit cpuaf_checker u_cpuaf_checker (.*);

`default_nettype wire

### tb/tb_cpu_alu_mov_add_sub_flags_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MOV/ADD/SUB/CMP execute unit with flags.

module tb_cpu_alu_mov_add_sub_flags_unit;
    import cpuaf_pkg::*;

    // Kinds above CMP are decoded as no-ops by the unit.
    localparam logic [2:0] KIND_IGNORED_FIRST = KIND_CMP + 3'd1;
    localparam logic [2:0] KIND_IGNORED_LAST  = 3'd7;

    // Word register codes, byte register codes and segment register codes.
    localparam logic [2:0] REG_AX = 3'd0;
    localparam logic [2:0] REG_CX = 3'd1;
    localparam logic [2:0] REG_DX = 3'd2;
    localparam logic [2:0] REG_BX = 3'd3;
    localparam logic [2:0] REG_AL = 3'd0;
    localparam logic [2:0] REG_CL = 3'd1;
    localparam logic [2:0] REG_AH = 3'd4;
    localparam logic [2:0] REG_CH = 3'd5;
    localparam logic [2:0] REG_BH = 3'd7;
    localparam logic [2:0] SEG_CS = 3'd1;
    localparam logic [2:0] SEG_SS = 3'd2;
    localparam logic [2:0] SEG_DS = 3'd3;
    // Setting this bit in a segment code must not change which segment is used.
    localparam logic [2:0] SEG_ALIAS_BIT = 3'd4;

    // Idling phases, stepped through as the run goes on.
    localparam int PH_NONE     = 0;
    localparam int PH_SENDER   = 1;
    localparam int PH_RECEIVER = 2;
    localparam int PH_BOTH     = 3;

    localparam int WORK_ITEMS     = 1180;
    localparam int LONG_HOLD      = 64;
    localparam int SETTLE_CYCLES  = 10;

    // One decoded instruction; drain makes the sender wait until every
    // outstanding result has come back before offering it.
    typedef struct packed {
        logic [2:0]  kind;
        logic        wide;
        logic        dseg;
        logic [2:0]  didx;
        logic [1:0]  stype;
        logic [2:0]  sidx;
        logic [15:0] imm;
        logic        drain;
    } instr_t;

    // What the unit should return for one instruction.
    typedef struct packed {
        logic [15:0] value;
        logic        written;
        flags_t      flags;
    } retire_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic   s_valid   = 1'b0;
    logic   s_ready;
    instr_t cur_instr = '0;
    logic   m_valid;
    logic   m_ready   = 1'b1;

    logic [15:0] m_result_value;
    logic        m_written;
    logic        m_zero_flag;
    logic        m_sign_flag;
    logic        m_parity_flag;
    logic        m_carry_flag;
    logic        m_overflow_flag;
    logic        m_aux_flag;

    // Architectural state of the predictor.
    logic [15:0] gpr [GEN_DEPTH];
    logic [15:0] sreg [SEG_DEPTH];
    flags_t      arch_flags;

    instr_t  instr_backlog[$];
    retire_t pending_results[$];
    retire_t predicted;
    retire_t want;

    logic s_fired = 1'b0;
    int   n_sent      = 0;
    int   n_received  = 0;
    int   n_ignored   = 0;
    int   n_carry     = 0;
    int   n_overflow  = 0;
    int   n_aux       = 0;
    int   errors      = 0;
    int   hold_left   = 0;
    int   hold_events = 0;

    cpu_alu_mov_add_sub_flags_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (cur_instr.kind),
        .s_wide            (cur_instr.wide),
        .s_dest_is_segment (cur_instr.dseg),
        .s_dest_index      (cur_instr.didx),
        .s_src_type        (cur_instr.stype),
        .s_src_index       (cur_instr.sidx),
        .s_immediate       (cur_instr.imm),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_value    (m_result_value),
        .m_written         (m_written),
        .m_zero_flag       (m_zero_flag),
        .m_sign_flag       (m_sign_flag),
        .m_parity_flag     (m_parity_flag),
        .m_carry_flag      (m_carry_flag),
        .m_overflow_flag   (m_overflow_flag),
        .m_aux_flag        (m_aux_flag)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Byte codes 0..3 are the low halves of registers 0..3, codes 4..7 the
    // high halves of the same registers.
    function automatic logic [15:0] read_gpr(input logic [2:0] code, input logic w);
        if (w)
            return gpr[code];
        if (code < 3'd4)
            return {8'h00, gpr[code][7:0]};
        return {8'h00, gpr[code[1:0]][15:8]};
    endfunction

    function automatic void write_gpr(input logic [2:0] code, input logic w,
                                      input logic [15:0] v);
        if (w)
            gpr[code] = v;
        else if (code < 3'd4)
            gpr[code][7:0] = v[7:0];
        else
            gpr[code[1:0]][15:8] = v[7:0];
    endfunction

    // Executes one instruction on the predictor's state and returns the
    // result the unit should produce for it.
    function automatic retire_t execute_instr(input instr_t ins);
        retire_t     res;
        logic        w;
        logic [16:0] mask;
        logic [16:0] sgn;
        logic [16:0] a;
        logic [16:0] b;
        logic [16:0] r;
        flags_t      f;
        res.value   = '0;
        res.written = 1'b0;
        res.flags   = arch_flags;
        // Unknown kinds and memory sources leave everything untouched.
        if (ins.kind > KIND_CMP || ins.stype == SRC_MEM) begin
            n_ignored++;
            return res;
        end
        if (ins.kind == KIND_MOV) begin
            // Any segment operand forces a full word move.
            w = ins.wide || ins.dseg || ins.stype == SRC_SEG;
            case (ins.stype)
                SRC_IMM: b = w ? {1'b0, ins.imm} : {9'h0, ins.imm[7:0]};
                SRC_GEN: b = {1'b0, read_gpr(ins.sidx, w)};
                default: b = {1'b0, sreg[ins.sidx[1:0]]};
            endcase
            if (ins.dseg)
                sreg[ins.didx[1:0]] = b[15:0];
            else
                write_gpr(ins.didx, w, b[15:0]);
            res.value   = b[15:0];
            res.written = 1'b1;
            return res;
        end
        // Arithmetic never touches segment registers.
        if (ins.dseg || ins.stype == SRC_SEG) begin
            n_ignored++;
            return res;
        end
        mask = ins.wide ? 17'h0FFFF : 17'h000FF;
        sgn  = ins.wide ? 17'h08000 : 17'h00080;
        a = {1'b0, read_gpr(ins.didx, ins.wide)};
        b = ins.stype == SRC_IMM ? {1'b0, ins.imm} & mask
                                 : {1'b0, read_gpr(ins.sidx, ins.wide)};
        f = '0;
        if (ins.kind == KIND_ADD) begin
            r    = (a + b) & mask;
            f.cf = (a + b) > mask;
            f.of = ((a ^ r) & (b ^ r) & sgn) != '0;
        end else begin
            r    = (a - b) & mask;
            f.cf = b > a;
            f.of = ((a ^ b) & (a ^ r) & sgn) != '0;
        end
        f.af = a[4] ^ b[4] ^ r[4];
        f.zf = r == '0;
        f.sf = (r & sgn) != '0;
        f.pf = ~^r[7:0];
        arch_flags = f;
        n_carry    += f.cf;
        n_overflow += f.of;
        n_aux      += f.af;
        // CMP reports the difference but keeps the destination.
        if (ins.kind != KIND_CMP)
            write_gpr(ins.didx, ins.wide, r[15:0]);
        res.value   = r[15:0];
        res.written = ins.kind != KIND_CMP;
        res.flags   = f;
        return res;
    endfunction

    function automatic logic does_work(input instr_t ins);
        if (ins.kind > KIND_CMP || ins.stype == SRC_MEM)
            return 1'b0;
        return ins.kind == KIND_MOV || !(ins.dseg || ins.stype == SRC_SEG);
    endfunction

    function automatic instr_t make_instr(input logic [2:0] kind, input logic w,
                                          input logic dseg, input logic [2:0] didx,
                                          input logic [1:0] stype, input logic [2:0] sidx,
                                          input logic [15:0] imm);
        instr_t ins;
        ins.kind  = kind;
        ins.wide  = w;
        ins.dseg  = dseg;
        ins.didx  = didx;
        ins.stype = stype;
        ins.sidx  = sidx;
        ins.imm   = imm;
        ins.drain = 1'b0;
        return ins;
    endfunction

    // Values sitting at the carry, sign and overflow boundaries.
    function automatic logic [15:0] corner_imm(input int idx);
        case (idx)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'h007F;
            5: return 16'h0080;
            6: return 16'h00FF;
            default: return 16'h000F;
        endcase
    endfunction

    // Mostly well-formed instructions; a few no-op kinds, memory sources and
    // segment arithmetic are mixed in as noise.
    function automatic instr_t random_instr();
        instr_t ins;
        int     pick;
        ins  = '0;
        pick = $urandom_range(99);
        if (pick < 4)
            ins.kind = 3'($urandom_range(KIND_IGNORED_LAST, KIND_IGNORED_FIRST));
        else if (pick < 34)
            ins.kind = KIND_MOV;
        else if (pick < 56)
            ins.kind = KIND_ADD;
        else if (pick < 78)
            ins.kind = KIND_SUB;
        else
            ins.kind = KIND_CMP;
        ins.wide = 1'($urandom_range(1));
        ins.didx = 3'($urandom_range(7));
        ins.sidx = 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 2)
            ins.stype = SRC_MEM;
        else if (pick < 45)
            ins.stype = SRC_IMM;
        else if (pick < (ins.kind == KIND_MOV ? 80 : 97))
            ins.stype = SRC_GEN;
        else
            ins.stype = SRC_SEG;
        ins.dseg = $urandom_range(99) < (ins.kind == KIND_MOV ? 15 : 3);
        if ($urandom_range(3) == 0)
            ins.imm = corner_imm($urandom_range(7));
        else
            ins.imm = 16'($urandom_range(16'hFFFF));
        return ins;
    endfunction

    // The idling phase advances every hundred accepted instructions, so each
    // kind of gap lands on many different instruction sequences.
    function automatic int idle_phase();
        return (n_sent / 100) % 4;
    endfunction

    function automatic logic sender_idles();
        case (idle_phase())
            PH_NONE:   return 1'b0;
            PH_SENDER: return $urandom_range(99) < 50;
            PH_BOTH:   return $urandom_range(99) < 7;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stalls();
        case (idle_phase())
            PH_NONE:     return 1'b0;
            PH_RECEIVER: return $urandom_range(99) < 50;
            PH_BOTH:     return $urandom_range(99) < 7;
            default:     return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s expected %h, actual %h", $time, name, want_v, got_v);
        end
    endtask

    // Sender. A new instruction is put on the port only when the previous one
    // has been transferred or none is being offered, so valid and the payload
    // hold steady while the unit stalls. An instruction marked for drain
    // waits until every outstanding result has been returned.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fired) begin
            if (instr_backlog.size() != 0
                    && !(instr_backlog[0].drain && pending_results.size() != 0)
                    && !sender_idles()) begin
                cur_instr <= instr_backlog.pop_front();
                s_valid   <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver. Twice in the run it holds ready low for a long stretch while
    // the sender keeps offering, which fills the pipeline and must push back
    // on the input port.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if ((hold_events == 0 && n_received >= 300)
                     || (hold_events == 1 && n_received >= 900)) begin
            m_ready     <= 1'b0;
            hold_left   <= LONG_HOLD - 1;
            hold_events <= hold_events + 1;
        end else begin
            m_ready <= !receiver_stalls();
        end
    end

    // Scoreboard. Results are checked before the same edge's input transfer
    // is predicted; a correct unit never returns a result on the edge that
    // accepts its instruction, so this order does not hide anything.
    always @(posedge aclk) begin
        s_fired <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            n_received++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result %h returned with no instruction outstanding",
                         $time, m_result_value);
            end else begin
                want = pending_results.pop_front();
                check_field("result_value", want.value, m_result_value);
                check_field("written", 16'(want.written), 16'(m_written));
                check_field("zero_flag", 16'(want.flags.zf), 16'(m_zero_flag));
                check_field("sign_flag", 16'(want.flags.sf), 16'(m_sign_flag));
                check_field("parity_flag", 16'(want.flags.pf), 16'(m_parity_flag));
                check_field("carry_flag", 16'(want.flags.cf), 16'(m_carry_flag));
                check_field("overflow_flag", 16'(want.flags.of), 16'(m_overflow_flag));
                check_field("aux_flag", 16'(want.flags.af), 16'(m_aux_flag));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            predicted = execute_instr(cur_instr);
            pending_results.push_back(predicted);
            n_sent++;
        end
    end

    // Stimulus and end of run.
    initial begin
        instr_t ins;
        int     n_work;
        int     n_random;
        for (int i = 0; i < GEN_DEPTH; i++)
            gpr[i] = '0;
        for (int i = 0; i < SEG_DEPTH; i++)
            sreg[i] = '0;
        arch_flags = '0;

        // Directed part: byte halves, forced word moves with segments,
        // carry, overflow and zero at both widths, borrow at byte width, CMP
        // without write-back, and every way an instruction can be ignored.
        instr_backlog.push_back(make_instr(KIND_MOV, 1'b1, 1'b0, REG_AX, SRC_IMM, REG_AX, 16'hFFFF));
        instr_backlog.push_back(make_instr(KIND_MOV, 1'b0, 1'b0, REG_AH, SRC_IMM, REG_AX, 16'h1280));
        instr_backlog.push_back(make_instr(KIND_MOV, 1'b0, 1'b0, REG_CL, SRC_GEN, REG_AH, 16'h0000));
        instr_backlog.push_back(make_instr(KIND_MOV, 1'b0, 1'b1, SEG_SS | SEG_ALIAS_BIT,
                                           SRC_GEN, REG_AL, 16'h0000));
        instr_backlog.push_back(make_instr(KIND_MOV, 1'b0, 1'b0, REG_BX, SRC_SEG, SEG_SS, 16'h0000));
        instr_backlog.push_back(make_instr(KIND_MOV, 1'b0, 1'b1, SEG_CS, SRC_IMM, REG_AX, 16'h1234));
        instr_backlog.push_back(make_instr(KIND_ADD, 1'b1, 1'b0, REG_AX, SRC_IMM, REG_AX, 16'h7F01));
        instr_backlog.push_back(make_instr(KIND_MOV, 1'b1, 1'b0, REG_DX, SRC_IMM, REG_AX, 16'h7FFF));
        instr_backlog.push_back(make_instr(KIND_ADD, 1'b1, 1'b0, REG_DX, SRC_IMM, REG_AX, 16'h0001));
        instr_backlog.push_back(make_instr(KIND_MOV, 1'b0, 1'b0, REG_CL, SRC_IMM, REG_AX, 16'hFF00));
        instr_backlog.push_back(make_instr(KIND_SUB, 1'b0, 1'b0, REG_CL, SRC_IMM, REG_AX, 16'h0001));
        instr_backlog.push_back(make_instr(KIND_SUB, 1'b1, 1'b0, REG_DX, SRC_IMM, REG_AX, 16'h0001));
        instr_backlog.push_back(make_instr(KIND_CMP, 1'b1, 1'b0, REG_DX, SRC_GEN, REG_DX, 16'h0000));
        instr_backlog.push_back(make_instr(KIND_CMP, 1'b0, 1'b0, REG_AH, SRC_IMM, REG_AX, 16'h00FF));
        instr_backlog.push_back(make_instr(KIND_ADD, 1'b0, 1'b0, REG_BH, SRC_GEN, REG_CH, 16'h0000));
        instr_backlog.push_back(make_instr(KIND_ADD, 1'b0, 1'b0, REG_AL, SRC_IMM, REG_AX, 16'h0080));
        instr_backlog.push_back(make_instr(KIND_ADD, 1'b0, 1'b0, REG_AL, SRC_IMM, REG_AX, 16'h0080));
        instr_backlog.push_back(make_instr(KIND_ADD, 1'b1, 1'b1, SEG_DS, SRC_IMM, REG_AX, 16'h0001));
        instr_backlog.push_back(make_instr(KIND_SUB, 1'b1, 1'b0, REG_AX, SRC_SEG, SEG_CS, 16'h0000));
        instr_backlog.push_back(make_instr(KIND_IGNORED_FIRST, 1'b1, 1'b0, REG_AX, SRC_IMM,
                                           REG_AX, 16'hFFFF));
        instr_backlog.push_back(make_instr(KIND_IGNORED_LAST, 1'b0, 1'b0, REG_BX, SRC_GEN,
                                           REG_CX, 16'h0000));
        instr_backlog.push_back(make_instr(KIND_MOV, 1'b1, 1'b0, REG_AX, SRC_MEM, REG_AX, 16'hFFFF));
        instr_backlog.push_back(make_instr(KIND_MOV, 1'b0, 1'b1, SEG_DS, SRC_SEG,
                                           SEG_CS | SEG_ALIAS_BIT, 16'h0000));
        instr_backlog.push_back(make_instr(KIND_SUB, 1'b1, 1'b0, REG_BX, SRC_GEN, REG_CX, 16'h0000));

        // Random part, counted by instructions that actually do work. The
        // first random instruction and one in the middle wait for a drain.
        n_work   = 0;
        n_random = 0;
        while (n_work < WORK_ITEMS) begin
            ins       = random_instr();
            ins.drain = n_random == 0 || n_random == WORK_ITEMS / 2;
            n_work   += does_work(ins);
            n_random++;
            instr_backlog.push_back(ins);
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (instr_backlog.size() != 0 || s_valid)
            @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d instructions (%0d ignored) with %0d results checked and %0d long holds;",
                 n_sent, n_ignored, n_received, hold_events);
        $display("arithmetic set carry %0d, overflow %0d and aux carry %0d times.",
                 n_carry, n_overflow, n_aux);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
src/cpuaf_pkg.sv
src/cpuaf_ram.sv
src/cpuaf_regfile.sv
src/cpuaf_alu.sv
src/cpu_alu_mov_add_sub_flags_unit.sv
src/cpuaf_checker.sv
tb/tb_cpu_alu_mov_add_sub_flags_unit.sv
